// ===== rtl/color_sensor_frequency_calibrator_unit_macros.svh =====
// Assertion macros for the color sensor frequency calibrator.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef COLOR_SENSOR_FREQUENCY_CALIBRATOR_UNIT_MACROS_SVH
`define COLOR_SENSOR_FREQUENCY_CALIBRATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CSFC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/csfc_pkg.sv =====
// Shared types, constants and helpers for the color sensor frequency calibrator.
// No dependencies.
package csfc_pkg;

	localparam int FREQ_NUM      = 500000;
	localparam int PULSE_TIMEOUT = 250000;
	localparam int WHITE_RESET   = 1000;
	localparam int SCALE_MAX     = 255;
	localparam int CAL_SAMPLES   = 255;
	localparam int MEASURE_RESET = 16;

	localparam int PULSE_W = 18;
	localparam int FREQ_W  = 19;
	localparam int SUM_W   = 27;
	localparam int CNT_W   = 8;
	localparam int NUM_W   = 27;
	localparam int DEN_W   = 19;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int NUM_CH  = 3;

	// action / result kind codes
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WHITE = 2'd1;
	localparam logic [1:0] ACT_BLACK = 2'd2;
	localparam logic [1:0] ACT_BAD   = 2'd3;

	// channel codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_BAD   = 2'd3;

	// S2/S3 levels
	localparam logic [1:0] PINS_RED   = 2'b00;
	localparam logic [1:0] PINS_GREEN = 2'b11;
	localparam logic [1:0] PINS_BLUE  = 2'b01;

	// register map: word index is paddr[2]
	localparam int         APB_ADDR_W          = 3;
	localparam logic [0:0] REG_MEASURE_SAMPLES = 1'b0;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         channel;
		logic [PULSE_W-1:0] pulse_high_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [1:0]        result_channel;
		logic [1:0]        filter_select;
		logic [FREQ_W-1:0] average_frequency;
		logic [7:0]        scaled_value;
		logic              out_of_range;
	} out_item_t;

	typedef enum logic [1:0] {
		DIV_FREQ,
		DIV_AVG,
		DIV_MAP
	} div_sel_t;

	typedef struct packed {
		logic     load_item;
		logic     clr_freq;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_freq;
		logic     accum;
		logic     take_avg;
		logic     store_point;
		logic     prep_map;
		logic     set_empty;
		logic     take_map;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic item_ok;
		logic timeout;
		logic div_done;
		logic run_full;
		logic is_read;
		logic span_zero;
		logic out_free;
	} sts_t;

	function automatic logic [1:0] pins_for(input logic [1:0] ch);
		logic [1:0] p;
		case (ch)
			CH_GREEN: p = PINS_GREEN;
			CH_BLUE:  p = PINS_BLUE;
			default:  p = PINS_RED;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/csfc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on csfc_pkg.
module csfc_div
	import csfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [NUM_W-1:0]     quo_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/csfc_dp.sv =====
// Datapath: item and run registers, calibration points, divider operands, output register.
// Depends on csfc_pkg and csfc_div.
module csfc_dp
	import csfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_item,
	input  logic [CNT_W-1:0] measure_samples,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item
);

	in_item_t          item_q;
	logic [FREQ_W-1:0] freq_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        run_action_q;
	logic [1:0]        run_channel_q;
	logic [FREQ_W-1:0] avg_q;
	logic [FREQ_W-1:0] black_q [NUM_CH];
	logic [FREQ_W-1:0] white_q [NUM_CH];
	logic [FREQ_W-1:0] map_mag_q;
	logic [FREQ_W-1:0] span_mag_q;
	logic              map_neg_q;
	logic              span_zero_q;
	logic [7:0]        scaled_q;
	logic              flag_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic             restart;
	logic [SUM_W-1:0] sum_base;
	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] target;
	logic [FREQ_W-1:0] lo;
	logic [FREQ_W-1:0] hi;
	logic [FREQ_W:0]  diff;
	logic [FREQ_W:0]  span;
	logic [FREQ_W:0]  diff_neg;
	logic [FREQ_W:0]  span_neg;
	logic [NUM_W-1:0] times255;

	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	csfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// run bookkeeping
	assign restart  = (count_q == '0) || (item_q.action != run_action_q) ||
		(item_q.channel != run_channel_q);
	assign sum_base = restart ? '0 : sum_q;
	assign cnt_base = restart ? '0 : count_q;

	always_comb begin
		if (item_q.action == ACT_READ) begin
			target = (measure_samples == '0) ? CNT_W'(1) : measure_samples;
		end else begin
			target = CNT_W'(CAL_SAMPLES);
		end
	end

	// mapping operands, sign handled apart from the magnitudes
	assign lo       = black_q[item_q.channel];
	assign hi       = white_q[item_q.channel];
	assign diff     = {1'b0, avg_q} - {1'b0, lo};
	assign span     = {1'b0, hi} - {1'b0, lo};
	assign diff_neg = -diff;
	assign span_neg = -span;
	assign times255 = {map_mag_q, 8'b0} - {8'b0, map_mag_q};

	always_comb begin
		case (cmd.div_sel)
			DIV_FREQ: begin
				div_num = NUM_W'(FREQ_NUM);
				div_den = {1'b0, item_q.pulse_high_us};
			end
			DIV_AVG: begin
				div_num = sum_q;
				div_den = {{(DEN_W-CNT_W){1'b0}}, count_q};
			end
			DIV_MAP: begin
				div_num = times255;
				div_den = span_mag_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	always_comb begin
		sts.item_ok   = (item_q.action != ACT_BAD) && (item_q.channel != CH_BAD);
		sts.timeout   = (item_q.pulse_high_us == '0) ||
			(item_q.pulse_high_us > PULSE_W'(PULSE_TIMEOUT));
		sts.div_done  = div_done;
		sts.run_full  = count_q >= target;
		sts.is_read   = item_q.action == ACT_READ;
		sts.span_zero = span_zero_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// model state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			count_q       <= '0;
			run_action_q  <= ACT_READ;
			run_channel_q <= CH_RED;
			for (int i = 0; i < NUM_CH; i++) begin
				black_q[i] <= '0;
				white_q[i] <= FREQ_W'(WHITE_RESET);
			end
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.accum) begin
				sum_q         <= sum_base + {{(SUM_W-FREQ_W){1'b0}}, freq_q};
				count_q       <= cnt_base + 1'b1;
				run_action_q  <= item_q.action;
				run_channel_q <= item_q.channel;
			end else if (cmd.emit) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (cmd.store_point) begin
				if (item_q.action == ACT_WHITE) begin
					white_q[item_q.channel] <= avg_q;
				end else begin
					black_q[item_q.channel] <= avg_q;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_item;
		end
		if (cmd.clr_freq) begin
			freq_q <= '0;
		end else if (cmd.take_freq) begin
			freq_q <= div_quo[FREQ_W-1:0];
		end
		if (cmd.take_avg) begin
			avg_q    <= div_quo[FREQ_W-1:0];
			scaled_q <= '0;
			flag_q   <= 1'b0;
		end else if (cmd.set_empty) begin
			scaled_q <= '0;
			flag_q   <= 1'b1;
		end else if (cmd.take_map) begin
			if (map_neg_q) begin
				scaled_q <= '0;
				flag_q   <= div_quo != '0;
			end else if (div_quo > NUM_W'(SCALE_MAX)) begin
				scaled_q <= 8'(SCALE_MAX);
				flag_q   <= 1'b1;
			end else begin
				scaled_q <= div_quo[7:0];
				flag_q   <= 1'b0;
			end
		end
		if (cmd.prep_map) begin
			map_mag_q   <= diff[FREQ_W] ? diff_neg[FREQ_W-1:0] : diff[FREQ_W-1:0];
			span_mag_q  <= span[FREQ_W] ? span_neg[FREQ_W-1:0] : span[FREQ_W-1:0];
			map_neg_q   <= diff[FREQ_W] ^ span[FREQ_W];
			span_zero_q <= span == '0;
		end
		if (cmd.emit) begin
			out_q.result_kind       <= item_q.action;
			out_q.result_channel    <= item_q.channel;
			out_q.filter_select     <= pins_for(item_q.channel);
			out_q.average_frequency <= avg_q;
			out_q.scaled_value      <= scaled_q;
			out_q.out_of_range      <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== rtl/csfc_ctrl.sv =====
// Controller: sequences one item through frequency, accumulate, average and mapping or calibration-point steps.
// Depends on csfc_pkg.
module csfc_ctrl
	import csfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_FDIV,
		S_ACCUM,
		S_CHECK,
		S_ADIV,
		S_POINT,
		S_MSTART,
		S_MDIV,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_FREQ;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				if (!sts.item_ok) begin
					state_d = S_IDLE;
				end else if (sts.timeout) begin
					cmd.clr_freq = 1'b1;
					state_d = S_ACCUM;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_FREQ;
					state_d = S_FDIV;
				end
			end
			S_FDIV: begin
				if (sts.div_done) begin
					cmd.take_freq = 1'b1;
					state_d = S_ACCUM;
				end
			end
			S_ACCUM: begin
				cmd.accum = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.run_full) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_AVG;
					state_d = S_ADIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ADIV: begin
				if (sts.div_done) begin
					cmd.take_avg = 1'b1;
					state_d = S_POINT;
				end
			end
			S_POINT: begin
				if (sts.is_read) begin
					cmd.prep_map = 1'b1;
					state_d = S_MSTART;
				end else begin
					cmd.store_point = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_MSTART: begin
				if (sts.span_zero) begin
					cmd.set_empty = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_MAP;
					state_d = S_MDIV;
				end
			end
			S_MDIV: begin
				if (sts.div_done) begin
					cmd.take_map = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// ===== rtl/color_sensor_frequency_calibrator_unit.sv =====
// Top level of the color sensor frequency calibrator: APB register, controller, datapath.
// Depends on csfc_pkg, csfc_ctrl, csfc_dp and the assertion macro header.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_stall    in_item  (in_item_t)
//  out       source     out_valid/out_stall  out_item (out_item_t)
//  cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// One item at a time; the shared 27-step divider sets the pace.
// An ordinary sample runs the frequency divide; a timed-out pulse skips it.
// The last sample of a run adds the average divide, and a reading adds its mapping
// divide as well (not when the span is empty); a stalled output adds to the wait.
// A result waits in the output register; the next item is taken meanwhile.
// arst_n clears the run, restores calibration points, measure_samples = 16.
`include "color_sensor_frequency_calibrator_unit_macros.svh"

module color_sensor_frequency_calibrator_unit
	import csfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [CNT_W-1:0] measure_samples_q;
	logic             cfg_write;
	cmd_t             cmd;
	sts_t             sts;

	// Config register: written in the APB access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[APB_ADDR_W-1:2] == REG_MEASURE_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_samples_q <= CNT_W'(MEASURE_RESET);
		end else if (cfg_write) begin
			measure_samples_q <= pwdata[CNT_W-1:0];
		end
	end

	// Unmapped addresses read as zero.
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_MEASURE_SAMPLES) ?
		{{(32-CNT_W){1'b0}}, measure_samples_q} : 32'b0;

	// Controller issues commands, datapath reports status.
	csfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	csfc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_item         (in_item),
		.measure_samples (measure_samples_q),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_item        (out_item)
	);

	// Checks
	`CSFC_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "no stall after input transfer")
	`CSFC_ASSERT_SAME(a_cal_fields_zero, out_valid && out_item.result_kind != ACT_READ, out_item.scaled_value == '0 && !out_item.out_of_range, "calibration result with mapped fields set")
	`CSFC_ASSERT_SAME(a_avg_in_range, out_valid, out_item.average_frequency <= FREQ_W'(FREQ_NUM), "average frequency above full scale")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for color_sensor_frequency_calibrator_unit.
// Drives pulse-width samples and APB writes, predicts results and compares them.
// Depends on csfc_pkg and the unit's RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csfc_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before we give up
	localparam int SETTLE_CYCLES  = 200;   // longer than the last sample's work
	localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
	localparam int ITEM_BUDGET    = 1650;
	localparam int PHASE_ITEMS    = 220;
	localparam int CALM_TAIL      = 150;   // last items run with no idling
	localparam int MAX_REPORTS    = 10;
	localparam logic [APB_ADDR_W-1:0] MEASURE_ADDR = {REG_MEASURE_SAMPLES, 2'b00};

	// one row of the directed table; expected result typed in where obvious
	typedef struct {
		in_item_t  item;
		bit        typed;
		bit        gives_result;
		out_item_t result;
	} directed_row_t;

	logic            clk     = 1'b0;
	logic            arst_n  = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	in_item_t        in_item = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	out_item_t       out_item;
	logic            psel    = 1'b0;
	logic            penable = 1'b0;
	logic            pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]     pwdata  = '0;
	logic [31:0]     prdata;
	logic            pready;

	wire in_fire  = in_valid && !in_stall;
	wire out_fire = out_valid && !out_stall;

	// predictor state: mirror of the unit's run accumulator and calibration points
	logic [7:0]        cfg_samples = 8'(MEASURE_RESET);
	logic [SUM_W-1:0]  run_sum     = '0;
	logic [CNT_W-1:0]  run_count   = '0;
	logic [1:0]        run_act     = ACT_READ;
	logic [1:0]        run_ch      = CH_RED;
	logic [FREQ_W-1:0] black_ref [NUM_CH] = '{default: '0};
	logic [FREQ_W-1:0] white_ref [NUM_CH] = '{default: FREQ_W'(WHITE_RESET)};

	out_item_t pending_results [$];   // expected results, oldest first
	int        fail_count    = 0;
	int        items_sent    = 0;     // well-formed samples only
	int        cal_runs_left = 2;     // random full calibration runs still allowed
	bit        idle_enabled  = 1'b1;  // random gaps/stalls on both sides
	bit        hold_armed    = 1'b0;  // ask the receiver for one long hold-off

	color_sensor_frequency_calibrator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Directed table, measure_samples = 1, fresh calibration (black 0, white 1000).
	// Mapping is avg * 255 / 1000 here, so the typed rows are easy to verify.
	directed_row_t directed_rows [17] = '{
		// plain reading at full white
		'{'{ACT_READ, CH_RED, 18'd500}, 1'b1, 1'b1,
			'{ACT_READ, CH_RED, PINS_RED, 19'd1000, 8'd255, 1'b0}},
		// shortest pulse: far above white, clamped
		'{'{ACT_READ, CH_GREEN, 18'd1}, 1'b1, 1'b1,
			'{ACT_READ, CH_GREEN, PINS_GREEN, 19'd500000, 8'd255, 1'b1}},
		// timed-out pulse counts as zero frequency
		'{'{ACT_READ, CH_BLUE, 18'd0}, 1'b1, 1'b1,
			'{ACT_READ, CH_BLUE, PINS_BLUE, 19'd0, 8'd0, 1'b0}},
		// longest legal pulse
		'{'{ACT_READ, CH_RED, 18'd250000}, 1'b1, 1'b1,
			'{ACT_READ, CH_RED, PINS_RED, 19'd2, 8'd0, 1'b0}},
		// just past the timeout
		'{'{ACT_READ, CH_RED, 18'd250001}, 1'b1, 1'b1,
			'{ACT_READ, CH_RED, PINS_RED, 19'd0, 8'd0, 1'b0}},
		// all-ones width, also past the timeout
		'{'{ACT_READ, CH_GREEN, 18'h3FFFF}, 1'b1, 1'b1,
			'{ACT_READ, CH_GREEN, PINS_GREEN, 19'd0, 8'd0, 1'b0}},
		// undefined action / channel: dropped, no result
		'{'{ACT_BAD, CH_RED, 18'd100}, 1'b1, 1'b0, '0},
		'{'{ACT_READ, CH_BAD, 18'd100}, 1'b1, 1'b0, '0},
		'{'{ACT_BAD, CH_BAD, 18'h3FFFF}, 1'b1, 1'b0, '0},
		// mid-span, truncated
		'{'{ACT_READ, CH_BLUE, 18'd1000}, 1'b1, 1'b1,
			'{ACT_READ, CH_BLUE, PINS_BLUE, 19'd500, 8'd127, 1'b0}},
		'{'{ACT_READ, CH_GREEN, 18'd777}, 1'b0, 1'b0, '0},
		'{'{ACT_READ, CH_BLUE, 18'd2}, 1'b1, 1'b1,
			'{ACT_READ, CH_BLUE, PINS_BLUE, 19'd250000, 8'd255, 1'b1}},
		// calibration sample, then a reading restarts the run
		'{'{ACT_WHITE, CH_RED, 18'd500}, 1'b0, 1'b0, '0},
		'{'{ACT_READ, CH_RED, 18'd500}, 1'b0, 1'b0, '0},
		// an undefined item inside a black run must not break it
		'{'{ACT_BLACK, CH_BLUE, 18'd3}, 1'b0, 1'b0, '0},
		'{'{ACT_BAD, CH_BLUE, 18'd3}, 1'b0, 1'b0, '0},
		'{'{ACT_BLACK, CH_BLUE, 18'd3}, 1'b0, 1'b0, '0}
	};

	function automatic string describe(input out_item_t r);
		return $sformatf("kind=%0d ch=%0d pins=%0d avg=%0d scaled=%0d oor=%0d",
			r.result_kind, r.result_channel, r.filter_select,
			r.average_frequency, r.scaled_value, r.out_of_range);
	endfunction

	function automatic void note_failure(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] %s", $time, msg);
		fail_count++;
	endfunction

	// Advance the predictor by one accepted sample; returns 1 when a run completes.
	function automatic bit predict_calibrator(input in_item_t it, output out_item_t res);
		int unsigned       freq;
		int unsigned       target;
		logic [FREQ_W-1:0] avg;
		longint            lo;
		longint            hi;
		longint            mapped;
		res = '0;
		if (it.action == ACT_BAD || it.channel == CH_BAD)
			return 1'b0;
		// a new action or channel starts the run over
		if (run_count == 0 || it.action != run_act || it.channel != run_ch) begin
			run_sum   = '0;
			run_count = '0;
			run_act   = it.action;
			run_ch    = it.channel;
		end
		if (it.pulse_high_us == 0 || it.pulse_high_us > PULSE_TIMEOUT)
			freq = 0;
		else
			freq = FREQ_NUM / int'(it.pulse_high_us);
		run_sum   = run_sum + freq[SUM_W-1:0];
		run_count = run_count + 1'b1;
		if (it.action == ACT_READ)
			target = (cfg_samples == 0) ? 1 : cfg_samples;
		else
			target = CAL_SAMPLES;
		// a count lowered mid-run completes at once; average uses the real count
		if (run_count < target)
			return 1'b0;
		avg = FREQ_W'(run_sum / run_count);
		res.result_kind       = it.action;
		res.result_channel    = it.channel;
		res.average_frequency = avg;
		case (it.channel)
			CH_GREEN: res.filter_select = PINS_GREEN;
			CH_BLUE:  res.filter_select = PINS_BLUE;
			default:  res.filter_select = PINS_RED;
		endcase
		case (it.action)
			ACT_WHITE: white_ref[it.channel] = avg;
			ACT_BLACK: black_ref[it.channel] = avg;
			default: begin
				lo = black_ref[it.channel];
				hi = white_ref[it.channel];
				if (hi == lo) begin
					res.out_of_range = 1'b1;   // empty span
				end else begin
					// signed, truncated toward zero; inverted spans map the same way
					mapped = ((longint'(avg) - lo) * SCALE_MAX) / (hi - lo);
					if (mapped < 0) begin
						res.out_of_range = 1'b1;
					end else if (mapped > SCALE_MAX) begin
						res.scaled_value = 8'(SCALE_MAX);
						res.out_of_range = 1'b1;
					end else begin
						res.scaled_value = mapped[7:0];
					end
				end
			end
		endcase
		run_sum   = '0;
		run_count = '0;
		return 1'b1;
	endfunction

	function automatic logic [PULSE_W-1:0] random_width();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)  return '0;                                       // timeout
		if (pick < 8)  return PULSE_W'($urandom_range(PULSE_TIMEOUT + 1, 18'h3FFFF));
		if (pick < 11) return PULSE_W'($urandom_range(1, 10));
		if (pick < 16) return PULSE_W'($urandom_range(240000, PULSE_TIMEOUT));
		return PULSE_W'($urandom_range(300, 5000));
	endfunction

	// One transfer on the sample channel. Valid stays high between back-to-back
	// items; the predictor runs at the edge the unit accepts the item.
	task automatic offer_item(input in_item_t it, input bit typed = 1'b0,
			input bit typed_has = 1'b0, input out_item_t typed_res = '0);
		out_item_t res;
		bit        has;
		if (idle_enabled && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		has = predict_calibrator(it, res);
		if (typed) begin
			has = typed_has;
			res = typed_res;
		end
		if (has)
			pending_results.push_back(res);
		if (it.action != ACT_BAD && it.channel != CH_BAD)
			items_sent++;
	endtask

	// A run of samples of one action and channel; wide picks any width.
	task automatic send_run(input logic [1:0] act, input logic [1:0] ch, input int count,
			input bit wide, input int lo, input int hi);
		in_item_t it;
		repeat (count) begin
			it.action        = act;
			it.channel       = ch;
			it.pulse_high_us = wide ? random_width() : PULSE_W'($urandom_range(lo, hi));
			offer_item(it);
		end
	endtask

	// Wait for every expected result, then for any result-free work to finish.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= MEASURE_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_measure_readback(input logic [7:0] want);
		logic [31:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd !== {24'd0, want})
			note_failure($sformatf("measure_samples readback: expected %0d, got %0h",
				want, rd));
	endtask

	task automatic set_measure_samples(input logic [7:0] value);
		logic [31:0] rd;
		apb_access(1'b1, {24'd0, value}, rd);
		cfg_samples = value;
		check_measure_readback(value);
	endtask

	// Pick one run shape: mostly complete readings, some calibration, some truncated
	// runs (a later run of another action or channel restarts them) and some noise.
	task automatic random_run();
		int         pick;
		int         target;
		logic [1:0] act;
		logic [1:0] ch;
		in_item_t   it;
		target = (cfg_samples == 0) ? 1 : cfg_samples;
		pick   = $urandom_range(0, 99);
		ch     = 2'($urandom_range(0, 2));
		if (pick < 80) begin
			send_run(ACT_READ, ch, target, 1'b1, 0, 0);
		end else if (pick < 82 && cal_runs_left > 0) begin
			cal_runs_left--;
			if ($urandom_range(0, 1))
				send_run(ACT_WHITE, ch, CAL_SAMPLES, 1'b0, 250, 700);
			else
				send_run(ACT_BLACK, ch, CAL_SAMPLES, 1'b0, 2000, 10000);
		end else if (pick < 92) begin
			act = 2'($urandom_range(0, 2));
			if (act == ACT_READ)
				send_run(act, ch, (target > 1) ? $urandom_range(1, target - 1) : 1,
					1'b1, 0, 0);
			else
				send_run(act, ch, $urandom_range(1, 20), 1'b1, 0, 0);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				it.action        = 2'($urandom_range(0, 3));
				it.channel       = 2'($urandom_range(0, 3));
				it.pulse_high_us = random_width();
				offer_item(it);
			end
		end
	endtask

	// Result side: check each transfer against the oldest expectation, then
	// decide the stall for the next cycle (random bursts or one long hold).
	always @(posedge clk) begin : result_monitor
		out_item_t want;
		int        stall_left;
		int        hold_left;
		if (arst_n && out_fire) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: %s", describe(out_item)));
			end else begin
				want = pending_results.pop_front();
				if (out_item.result_kind !== want.result_kind
						|| out_item.result_channel !== want.result_channel
						|| out_item.filter_select !== want.filter_select
						|| out_item.average_frequency !== want.average_frequency
						|| out_item.scaled_value !== want.scaled_value
						|| out_item.out_of_range !== want.out_of_range)
					note_failure($sformatf("result mismatch: expected %s, got %s",
						describe(want), describe(out_item)));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_armed) begin
			hold_armed = 1'b0;
			hold_left  = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Ends the run if nothing moves on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (in_fire || out_fire || psel || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int          row;
		int          phase;
		int          phase_end;
		logic [7:0]  setting;
		logic [7:0]  schedule [6];
		schedule = '{8'd0, 8'd1, 8'd16, 8'd6, 8'd2, 8'd11};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the register, then single-sample readings
		check_measure_readback(8'(MEASURE_RESET));
		set_measure_samples(8'd1);
		for (row = 0; row < $size(directed_rows); row++)
			offer_item(directed_rows[row].item, directed_rows[row].typed,
				directed_rows[row].gives_result, directed_rows[row].result);
		quiesce();

		// Calibration scenarios with fixed widths: equal black and white on red
		// give an empty span; a bright black point on green inverts its span.
		set_measure_samples(8'd3);
		send_run(ACT_BLACK, CH_RED, CAL_SAMPLES, 1'b0, 1000, 1000);
		send_run(ACT_WHITE, CH_RED, CAL_SAMPLES, 1'b0, 1000, 1000);
		send_run(ACT_READ, CH_RED, 3, 1'b0, 700, 700);
		send_run(ACT_BLACK, CH_GREEN, CAL_SAMPLES, 1'b0, 100, 100);
		send_run(ACT_READ, CH_GREEN, 3, 1'b0, 200, 200);    // inside inverted span
		send_run(ACT_READ, CH_GREEN, 3, 1'b0, 50, 50);      // below zero
		send_run(ACT_READ, CH_GREEN, 3, 1'b0, 1000, 1000);  // above full scale
		quiesce();

		// Longest reading count, left unfinished; lowering the count then
		// completes the run on its next sample.
		set_measure_samples(8'd255);
		send_run(ACT_READ, CH_BLUE, 40, 1'b1, 0, 0);
		quiesce();
		set_measure_samples(8'd4);
		send_run(ACT_READ, CH_BLUE, 1, 1'b1, 0, 0);
		quiesce();

		// Random phases, each with its own count setting and idling mode.
		for (phase = 0; items_sent < ITEM_BUDGET; phase++) begin
			setting = (phase < $size(schedule)) ? schedule[phase] :
				8'($urandom_range(1, 24));
			set_measure_samples(setting);
			idle_enabled = ($urandom_range(0, 3) != 0);
			// one result per sample here, so a long hold backs the unit up
			if (setting == 1 && ITEM_BUDGET - items_sent >= CALM_TAIL)
				hold_armed = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < ITEM_BUDGET) begin
				if (ITEM_BUDGET - items_sent < CALM_TAIL)
					idle_enabled = 1'b0;
				random_run();
			end
			quiesce();
		end

		if (fail_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
